@@ rtl/core/fwsc_pkg.sv @@
`default_nettype none
package fwsc_pkg;

  localparam int unsigned StoreAw   = 11;
  localparam int unsigned FifoDepth = 1024;
  localparam int unsigned FifoAw    = 10;

  localparam logic [15:0] FifoFull  = 16'(FifoDepth);
  localparam logic [15:0] FifoHalf  = 16'h0200;
  localparam logic [15:0] MonoMin   = 16'd370;

  localparam logic [7:0]  Silence   = 8'h80;

  // bus functions
  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncTick  = 2'd2;

  // result kinds
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindAck   = 2'd1;
  localparam logic [1:0] KindSmp   = 2'd2;

  // register map
  localparam logic [11:0] AddrEnable  = 12'h801;
  localparam logic [11:0] AddrControl = 12'h802;
  localparam logic [11:0] AddrFmode   = 12'h803;
  localparam logic [11:0] AddrStatus  = 12'h804;
  localparam logic [11:0] AddrWave    = 12'h805;
  localparam logic [11:0] AddrVolume  = 12'h806;
  localparam logic [11:0] AddrVoiceLo = 12'h810;
  localparam logic [11:0] AddrVoiceHi = 12'h830;

  localparam logic [7:0] ModeFifo = 8'd1;
  localparam logic [7:0] ModeWave = 8'd2;

  localparam logic [2:0] VolFull = 3'd7;

  function automatic logic [15:0] vol_scale(input logic [2:0] lvl);
    logic [15:0] m;
    case (lvl)
      3'd0: m = 16'd8192;
      3'd1: m = 16'd9362;
      3'd2: m = 16'd10922;
      3'd3: m = 16'd13107;
      3'd4: m = 16'd16384;
      3'd5: m = 16'd21845;
      3'd6: m = 16'd32768;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] vol_bias(input logic [2:0] lvl);
    logic [7:0] b;
    case (lvl)
      3'd0: b = 8'd112;
      3'd1: b = 8'd110;
      3'd2: b = 8'd107;
      3'd3: b = 8'd103;
      3'd4: b = 8'd96;
      3'd5: b = 8'd86;
      3'd6: b = 8'd64;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fifo_wavetable_sound_chip_top.sv @@
`default_nettype none
// Four-voice wavetable / FIFO sound chip.
// Slave stream: one beat is a bus read, a bus write or a sub-tick.
// Master stream: a read reply, a write acknowledge, or 23/24 audio samples
// (24 when subtick_index[2:0] is 7); tlast marks the final beat of an item
// and tuser the interrupt pulse (last sub-tick sample, nonzero status write).
// Items are handled one at a time; s_axis_tready is high only while idle.
// A register access or a write loads its reply beat in StBus; a store read
// loads it in StRdWait, from the registered read port of the store.
// A sub-tick makes its samples one by one: a FIFO sample is read from the
// store (channel A, then channel B when stereo), a wavetable sample sums
// four voices, each a phase add, a store read and an accumulate, and
// silence needs no store read; all reads share the store's single read port.
// Reset: all registers of this module clear, then the store is zeroed in a
// clearing pass over all 2048 entries during which no beat is accepted.
// A stalled master side holds the output beat; the sequencer waits for
// the output register to be empty or taken before producing the next beat.
module fifo_wavetable_sound_chip_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[1:0], address[13:2], write_data[21:14], subtick_index[25:22]
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // kind[1:0], read_data[9:2], sample[17:10]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  // irq_pulse
  output logic             m_axis_tuser
);

  typedef enum logic [3:0] {
    StIdle, StBus, StRdWait, StStart, StSamp, StRdA, StRdB,
    StVAdd, StVRd, StVAcc, StScale, StFin, StEmit
  } state_e;

  localparam int unsigned Aw = fwsc_pkg::StoreAw;
  localparam int unsigned Fw = fwsc_pkg::FifoAw;

  state_e state_q;

  // latched item
  logic [1:0]  func_q;
  logic [11:0] addr_q;
  logic [7:0]  wd_q;

  // chip registers
  logic [7:0]  en_q, ctl_q, fmode_q, status_q, wave_q;
  logic [2:0]  vol_q;
  logic [31:0] freq_q [4];
  logic [31:0] phase_q [4];
  logic [15:0] rp_q, wpa_q, wpb_q;
  logic        play_q;

  // sub-tick sequencing
  logic        n24_q, stereo_q, tick_irq_q;
  logic [4:0]  idx_q;
  logic [1:0]  voice_q;
  logic [9:0]  acc_q;
  logic [7:0]  sa_q, smp_q;

  // output register
  logic        m_valid_q, out_last_q, out_irq_q;
  logic        m_valid_d;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_rd_q, out_smp_q;

  // store
  logic          st_we, st_ready;
  logic [Aw-1:0] st_waddr, st_raddr;
  logic [7:0]    st_rdata, scaled;

  fwsc_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (wd_q),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata),
    .ready_o (st_ready)
  );

  fwsc_scale u_scale (
    .clk_i    (clk_i),
    .smp_i    (smp_q),
    .vol_i    (vol_q),
    .scaled_o (scaled)
  );

  assign s_axis_tready = (state_q == StIdle) && st_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, out_smp_q, out_rd_q, out_kind_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_irq_q;

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // fill levels
  logic [15:0] fa, fb;
  assign fa = wpa_q - rp_q;
  assign fb = wpb_q - rp_q;

  // address decode
  logic is_store, is_voice;
  logic [1:0] vch;
  logic [2:0] vch_w;
  logic [4:0] vsh;
  assign is_store = !addr_q[11];
  assign is_voice = (addr_q >= fwsc_pkg::AddrVoiceLo) && (addr_q < fwsc_pkg::AddrVoiceHi);
  assign vch_w    = addr_q[5:3] - 3'd2;
  assign vch      = vch_w[1:0];
  assign vsh      = {~addr_q[1:0], 3'b000};

  // output beat loads: register reply or ack, store reply, sample
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    case (state_q)
      StBus: begin
        if (out_free && ((func_q != fwsc_pkg::FuncRead) || !is_store)) m_valid_d = 1'b1;
      end
      StRdWait: m_valid_d = 1'b1;
      StEmit: begin
        if (out_free) m_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // register read data
  logic [7:0]  reg_rd;
  logic [31:0] vword;
  always_comb begin
    vword = addr_q[2] ? freq_q[vch] : phase_q[vch];
    reg_rd = 8'd0;
    if (is_voice) begin
      reg_rd = 8'(vword >> vsh);
    end else begin
      case (addr_q)
        fwsc_pkg::AddrEnable:  reg_rd = en_q;
        fwsc_pkg::AddrControl: reg_rd = ctl_q;
        fwsc_pkg::AddrFmode:   reg_rd = fmode_q;
        fwsc_pkg::AddrStatus:  reg_rd = status_q;
        fwsc_pkg::AddrWave:    reg_rd = wave_q;
        fwsc_pkg::AddrVolume:  reg_rd = {vol_q, 5'd0};
        default:               reg_rd = 8'd0;
      endcase
    end
  end

  // FIFO push
  logic        push_b, push_ok;
  logic [15:0] push_wp, push_cnt, push_cnt1;
  logic [7:0]  push_status;
  always_comb begin
    push_b    = addr_q[10];
    push_wp   = push_b ? wpb_q : wpa_q;
    push_cnt  = push_wp - rp_q;
    push_ok   = push_cnt < fwsc_pkg::FifoFull;
    push_cnt1 = push_cnt + 16'd1;
    push_status = status_q;
    if (!push_ok) begin
      push_status[push_b ? 3 : 1] = 1'b1;
    end else begin
      if (push_cnt1 >= fwsc_pkg::FifoHalf) push_status[push_b ? 2 : 0] = 1'b0;
      push_status[push_b ? 3 : 1] = (push_cnt1 >= fwsc_pkg::FifoFull);
    end
  end

  logic wr_fifo;
  assign wr_fifo = (en_q == fwsc_pkg::ModeFifo);

  always_comb begin
    st_we    = (state_q == StBus) && out_free && (func_q == fwsc_pkg::FuncWrite)
               && is_store && (!wr_fifo || push_ok);
    st_waddr = wr_fifo ? {push_b, push_wp[Fw-1:0]} : addr_q[Aw-1:0];
  end

  // store read address
  logic [23:0] vix;
  assign vix = phase_q[voice_q][23:0] + 24'h004000;
  always_comb begin
    case (state_q)
      StBus:   st_raddr = addr_q[Aw-1:0];
      StSamp:  st_raddr = {1'b0, rp_q[Fw-1:0]};
      StRdA:   st_raddr = {1'b1, rp_q[Fw-1:0]};
      default: st_raddr = {voice_q, vix[23:15]};
    endcase
  end

  // end-of-tick status update
  logic [7:0] fin_status;
  logic       fin_irq;
  always_comb begin
    fin_status = status_q;
    fin_irq    = 1'b0;
    if (wr_fifo && play_q) begin
      if (fa >= fwsc_pkg::FifoHalf) begin
        fin_status[0] = 1'b0;
      end else if (!status_q[0]) begin
        fin_irq = 1'b1;
        fin_status[0] = 1'b1;
      end
      fin_status[1] = (fa >= fwsc_pkg::FifoFull);
      if (ctl_q[1]) begin
        if (fb >= fwsc_pkg::FifoHalf) begin
          fin_status[2] = 1'b0;
        end else if (!status_q[2]) begin
          fin_irq = 1'b1;
          fin_status[2] = 1'b1;
        end
        fin_status[3] = (fb >= fwsc_pkg::FifoFull);
      end
    end
  end

  logic       play_nx;
  logic [9:0] acc_nx;
  logic [8:0] pair_sum;
  logic       last_smp;
  assign play_nx  = play_q && (fa != 16'd0) && !(stereo_q && (fb == 16'd0));
  assign acc_nx   = acc_q + {2'd0, st_rdata};
  assign pair_sum = {1'b0, sa_q} + {1'b0, st_rdata};
  assign last_smp = (idx_q == (n24_q ? 5'd23 : 5'd22));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      en_q       <= '0;
      ctl_q      <= '0;
      fmode_q    <= '0;
      status_q   <= '0;
      wave_q     <= '0;
      vol_q      <= '0;
      for (int i = 0; i < 4; i++) begin
        freq_q[i]  <= '0;
        phase_q[i] <= '0;
      end
      rp_q       <= '0;
      wpa_q      <= '0;
      wpb_q      <= '0;
      play_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      out_kind_q <= '0;
      out_rd_q   <= '0;
      out_smp_q  <= '0;
      out_last_q <= 1'b0;
      out_irq_q  <= 1'b0;
      n24_q      <= 1'b0;
      stereo_q   <= 1'b0;
      tick_irq_q <= 1'b0;
      idx_q      <= '0;
      voice_q    <= '0;
      acc_q      <= '0;
      sa_q       <= '0;
      smp_q      <= '0;
      func_q     <= '0;
      addr_q     <= '0;
      wd_q       <= '0;
    end else begin
      m_valid_q <= m_valid_d;

      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func_q <= s_axis_tdata[1:0];
            addr_q <= s_axis_tdata[13:2];
            wd_q   <= s_axis_tdata[21:14];
            n24_q  <= (s_axis_tdata[24:22] == 3'b111);
            if (s_axis_tdata[1:0] == fwsc_pkg::FuncTick) begin
              state_q <= StStart;
            end else if (s_axis_tdata[1:0] != 2'd3) begin
              state_q <= StBus;
            end
          end
        end

        StBus: begin
          if (out_free) begin
            if (func_q == fwsc_pkg::FuncRead) begin
              if (is_store) begin
                state_q <= StRdWait;
              end else begin
                if (addr_q == fwsc_pkg::AddrStatus) status_q <= status_q & 8'hFA;
                out_kind_q <= fwsc_pkg::KindRead;
                out_rd_q   <= reg_rd;
                out_smp_q  <= '0;
                out_last_q <= 1'b1;
                out_irq_q  <= 1'b0;
                state_q    <= StIdle;
              end
            end else begin
              out_kind_q <= fwsc_pkg::KindAck;
              out_rd_q   <= '0;
              out_smp_q  <= '0;
              out_last_q <= 1'b1;
              out_irq_q  <= (addr_q == fwsc_pkg::AddrStatus) && (wd_q != 8'd0);
              state_q    <= StIdle;
              if (is_store) begin
                if (wr_fifo) begin
                  status_q <= push_status;
                  if (push_ok) begin
                    if (push_b) wpb_q <= push_wp + 16'd1;
                    else        wpa_q <= push_wp + 16'd1;
                  end
                end
              end else if (is_voice) begin
                if (addr_q[2]) freq_q[vch][vsh +: 8]  <= wd_q;
                else           phase_q[vch][vsh +: 8] <= wd_q;
              end else begin
                case (addr_q)
                  fwsc_pkg::AddrEnable: begin
                    if (wd_q == fwsc_pkg::ModeFifo && !wr_fifo) begin
                      rp_q <= '0; wpa_q <= '0; wpb_q <= '0; play_q <= 1'b0;
                    end
                    en_q <= wd_q;
                  end
                  fwsc_pkg::AddrControl: begin
                    if (wr_fifo && ctl_q != wd_q) begin
                      rp_q <= '0; wpa_q <= '0; wpb_q <= '0; play_q <= 1'b0;
                    end
                    ctl_q <= wd_q;
                  end
                  fwsc_pkg::AddrFmode: begin
                    if (wd_q[7] && !fmode_q[7] && wr_fifo) begin
                      rp_q <= '0; wpa_q <= '0; wpb_q <= '0; play_q <= 1'b0;
                    end
                    fmode_q <= wd_q;
                  end
                  fwsc_pkg::AddrStatus: status_q <= wd_q;
                  fwsc_pkg::AddrWave:   wave_q   <= wd_q;
                  fwsc_pkg::AddrVolume: vol_q    <= wd_q[7:5];
                  default: ;
                endcase
              end
            end
          end
        end

        StRdWait: begin
          out_kind_q <= fwsc_pkg::KindRead;
          out_rd_q   <= st_rdata;
          out_smp_q  <= '0;
          out_last_q <= 1'b1;
          out_irq_q  <= 1'b0;
          state_q    <= StIdle;
        end

        StStart: begin
          stereo_q   <= ctl_q[1];
          tick_irq_q <= 1'b0;
          idx_q      <= '0;
          if (wr_fifo && !play_q && fa >= fwsc_pkg::FifoHalf) begin
            if (ctl_q[1]) begin
              if (fb >= fwsc_pkg::FifoHalf) begin
                status_q <= status_q & 8'hFA;
                play_q   <= 1'b1;
              end else if (fb == 16'd0 && fa >= fwsc_pkg::MonoMin) begin
                ctl_q[1] <= 1'b0;
              end
            end else begin
              status_q[0] <= 1'b0;
              play_q      <= 1'b1;
            end
          end
          state_q <= StSamp;
        end

        StSamp: begin
          if (wr_fifo) begin
            play_q <= play_nx;
            if (play_nx) begin
              state_q <= StRdA;
            end else begin
              smp_q   <= fwsc_pkg::Silence;
              state_q <= StScale;
            end
          end else if (en_q == fwsc_pkg::ModeWave) begin
            voice_q <= '0;
            acc_q   <= '0;
            state_q <= StVAdd;
          end else begin
            smp_q   <= fwsc_pkg::Silence;
            state_q <= StScale;
          end
        end

        StRdA: begin
          if (stereo_q) begin
            sa_q    <= st_rdata;
            state_q <= StRdB;
          end else begin
            smp_q   <= st_rdata;
            rp_q    <= rp_q + 16'd1;
            state_q <= StScale;
          end
        end

        StRdB: begin
          smp_q   <= pair_sum[8:1];
          rp_q    <= rp_q + 16'd1;
          state_q <= StScale;
        end

        StVAdd: begin
          phase_q[voice_q] <= phase_q[voice_q] + freq_q[voice_q];
          state_q <= StVRd;
        end

        StVRd: state_q <= StVAcc;

        StVAcc: begin
          acc_q <= acc_nx;
          if (voice_q == 2'd3) begin
            smp_q   <= acc_nx[9:2];
            state_q <= StScale;
          end else begin
            voice_q <= voice_q + 2'd1;
            state_q <= StVAdd;
          end
        end

        StScale: state_q <= last_smp ? StFin : StEmit;

        StFin: begin
          status_q   <= fin_status;
          tick_irq_q <= fin_irq;
          state_q    <= StEmit;
        end

        StEmit: begin
          if (out_free) begin
            out_kind_q <= fwsc_pkg::KindSmp;
            out_rd_q   <= '0;
            out_smp_q  <= scaled;
            out_last_q <= last_smp;
            out_irq_q  <= last_smp && tick_irq_q;
            idx_q      <= idx_q + 5'd1;
            state_q    <= last_smp ? StIdle : StSamp;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fwsc_store.sv @@
`default_nettype none
// 2 KB sample store, one write and one registered read port.
// After reset a clearing pass zeroes one entry a cycle.
module fwsc_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [fwsc_pkg::StoreAw-1:0]  waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic [fwsc_pkg::StoreAw-1:0]  raddr_i,
  output logic      [7:0]                    rdata_o,
  output logic                               ready_o
);

  logic [7:0] mem [2**fwsc_pkg::StoreAw];
  logic [fwsc_pkg::StoreAw:0] clr_q;

  assign ready_o = clr_q[fwsc_pkg::StoreAw];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!ready_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ready_o) begin
      mem[clr_q[fwsc_pkg::StoreAw-1:0]] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/fwsc_scale.sv @@
`default_nettype none
// Volume scaling: registered product, bias added after the register.
module fwsc_scale (
  input  wire logic       clk_i,
  input  wire logic [7:0] smp_i,
  input  wire logic [2:0] vol_i,
  output logic      [7:0] scaled_o
);

  logic [23:0] prod_q;
  logic [7:0]  smp_q;
  logic [2:0]  vol_q;

  always_ff @(posedge clk_i) begin
    prod_q <= smp_i * fwsc_pkg::vol_scale(vol_i);
    smp_q  <= smp_i;
    vol_q  <= vol_i;
  end

  assign scaled_o = (vol_q == fwsc_pkg::VolFull) ? smp_q
                  : prod_q[23:16] + fwsc_pkg::vol_bias(vol_q);

endmodule
`default_nettype wire
